@@ hw/rtl/ddds_pkg.sv @@
`timescale 1ns / 1ps

package ddds_pkg;

	// input value
	localparam int VALUE_W = 14;
	localparam int VALUE_MAX = (1 << VALUE_W) - 1;

	// BCD digits needed to hold any 14-bit value (16383)
	localparam int DIGIT_W = 4;
	localparam int BCD_DIGITS = 5;
	localparam int BCD_W = BCD_DIGITS * DIGIT_W;

	// double-dabble step counter: counts 0..VALUE_W
	localparam int STEP_W = $clog2(VALUE_W + 1);

	// display frame layout
	localparam int FRAME_BITS = 16;
	localparam int BIT_W = $clog2(FRAME_BITS);
	localparam int ADDR_W = 8;
	localparam int POS_W = 3;

	// digit queue between converter and serializer, power of two
	localparam int QUEUE_DEPTH = 2;

	typedef logic [BCD_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

	typedef struct packed {
		logic valid;
		bcd_t digits;
	} queue_req_t;

	// 10**n, elaboration only
	function automatic longint pow10(input int n);
		longint r;
		r = 1;
		for (int i = 0; i < n; i++) begin
			r = r * 10;
		end
		return r;
	endfunction

endpackage

@@ hw/rtl/ddds_value_if.sv @@
`timescale 1ns / 1ps

interface ddds_value_if;
	logic valid;
	logic ready;
	logic [ddds_pkg::VALUE_W-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

@@ hw/rtl/ddds_beat_if.sv @@
`timescale 1ns / 1ps

interface ddds_beat_if;
	logic valid;
	logic ready;
	logic data_bit;
	logic [ddds_pkg::POS_W-1:0] digit_position;
	logic [ddds_pkg::BIT_W-1:0] bit_index;
	logic frame_end;
	logic last;

	modport source (
		output valid, output data_bit, output digit_position, output bit_index,
		output frame_end, output last, input ready
	);
	modport sink (
		input valid, input data_bit, input digit_position, input bit_index,
		input frame_end, input last, output ready
	);
endinterface

@@ hw/rtl/ddds_front.sv @@
`timescale 1ns / 1ps

// Clamp and binary-to-BCD conversion, one double-dabble step per cycle.
module ddds_front #(
	parameter int DIGIT_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	ddds_value_if.sink values,
	output ddds_pkg::queue_req_t push,
	input logic push_ready
);

	localparam longint LIMIT = ddds_pkg::pow10(DIGIT_COUNT);
	localparam logic [ddds_pkg::VALUE_W-1:0] CLAMP =
		(LIMIT - 1 > longint'(ddds_pkg::VALUE_MAX)) ? '1 : ddds_pkg::VALUE_W'(LIMIT - 1);
	localparam logic [ddds_pkg::STEP_W-1:0] STEPS = ddds_pkg::STEP_W'(ddds_pkg::VALUE_W);

	logic busy_q;
	logic [ddds_pkg::STEP_W-1:0] step_q;
	logic [ddds_pkg::VALUE_W-1:0] sh_q;
	ddds_pkg::bcd_t bcd_q;
	ddds_pkg::bcd_t bcd_adj;
	logic [ddds_pkg::BCD_W-1:0] adj_flat;
	logic [ddds_pkg::VALUE_W-1:0] clamped;
	logic accept;
	logic stepping;

	assign values.ready = !busy_q;
	assign accept = values.valid && !busy_q;
	assign stepping = busy_q && (step_q != STEPS);
	assign clamped = (values.value > CLAMP) ? CLAMP : values.value;

	// add 3 to every digit of 5 or more before the shift
	always_comb begin
		for (int i = 0; i < ddds_pkg::BCD_DIGITS; i++) begin
			bcd_adj[i] = (bcd_q[i] >= ddds_pkg::DIGIT_W'(5)) ?
				bcd_q[i] + ddds_pkg::DIGIT_W'(3) : bcd_q[i];
		end
	end

	assign adj_flat = bcd_adj;

	assign push.valid = busy_q && (step_q == STEPS);
	assign push.digits = bcd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (accept) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (stepping) begin
			step_q <= step_q + 1'b1;
		end else if (push.valid && push_ready) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sh_q <= clamped;
			bcd_q <= '0;
		end else if (stepping) begin
			sh_q <= {sh_q[ddds_pkg::VALUE_W-2:0], 1'b0};
			bcd_q <= ddds_pkg::bcd_t'({adj_flat[ddds_pkg::BCD_W-2:0],
				sh_q[ddds_pkg::VALUE_W-1]});
		end
	end

endmodule

@@ hw/rtl/ddds_fifo.sv @@
`timescale 1ns / 1ps

// Short digit queue between converter and serializer.
module ddds_fifo (
	input logic clk,
	input logic arst_n,
	input ddds_pkg::queue_req_t push,
	output logic push_ready,
	output ddds_pkg::queue_req_t head,
	input logic pop
);

	localparam int PTR_W = (ddds_pkg::QUEUE_DEPTH > 1) ? $clog2(ddds_pkg::QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(ddds_pkg::QUEUE_DEPTH + 1);
	localparam logic [CNT_W-1:0] FULL = CNT_W'(ddds_pkg::QUEUE_DEPTH);

	ddds_pkg::bcd_t mem_q [ddds_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_push;
	logic do_pop;

	assign push_ready = (count_q != FULL);
	assign head.valid = (count_q != '0);
	assign head.digits = mem_q[rd_ptr_q];
	assign do_push = push.valid && push_ready;
	assign do_pop = pop && head.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.digits;
		end
	end

endmodule

@@ hw/rtl/ddds_back.sv @@
`timescale 1ns / 1ps

// Frame builder and bit serializer with a registered output beat.
module ddds_back #(
	parameter int DIGIT_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	input ddds_pkg::queue_req_t head,
	output logic pop,
	ddds_beat_if.source beats
);

	localparam int FR_W = $clog2(DIGIT_COUNT + 1);
	localparam logic [FR_W-1:0] LAST_FRAME = FR_W'(DIGIT_COUNT);
	localparam logic [ddds_pkg::BIT_W-1:0] TOP_BIT = ddds_pkg::BIT_W'(ddds_pkg::FRAME_BITS - 1);

	logic act_q;
	ddds_pkg::bcd_t cur_q;
	logic [FR_W-1:0] frame_q;
	logic [ddds_pkg::BIT_W-1:0] bit_q;
	logic out_valid_q;
	logic data_bit_q;
	logic [ddds_pkg::POS_W-1:0] pos_q;
	logic [ddds_pkg::BIT_W-1:0] bit_idx_q;
	logic frame_end_q;
	logic last_q;

	logic adv;
	logic final_beat;
	logic frame_done;
	logic [ddds_pkg::DIGIT_W-1:0] digit;
	logic [ddds_pkg::ADDR_W-1:0] addr;
	logic [ddds_pkg::FRAME_BITS-1:0] frame_word;

	// digit register address k shows decimal place DIGIT_COUNT - k
	always_comb begin
		digit = '0;
		for (int i = 0; i < ddds_pkg::BCD_DIGITS; i++) begin
			if (int'(frame_q) == DIGIT_COUNT - i) begin
				digit = cur_q[i];
			end
		end
	end

	assign addr = ddds_pkg::ADDR_W'(frame_q);
	assign frame_word = {addr, (ddds_pkg::FRAME_BITS - ddds_pkg::ADDR_W
		- ddds_pkg::DIGIT_W)'(0), digit};

	assign adv = act_q && (!out_valid_q || beats.ready);
	assign frame_done = (bit_q == '0);
	assign final_beat = frame_done && (frame_q == LAST_FRAME);
	assign pop = head.valid && (!act_q || (adv && final_beat));

	assign beats.valid = out_valid_q;
	assign beats.data_bit = data_bit_q;
	assign beats.digit_position = pos_q;
	assign beats.bit_index = bit_idx_q;
	assign beats.frame_end = frame_end_q;
	assign beats.last = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			frame_q <= '0;
			bit_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (beats.ready) begin
				out_valid_q <= 1'b0;
			end
			// next value starts right behind the final beat
			if (pop) begin
				act_q <= 1'b1;
				frame_q <= FR_W'(1);
				bit_q <= TOP_BIT;
			end else if (adv) begin
				if (frame_done) begin
					bit_q <= TOP_BIT;
					if (final_beat) begin
						act_q <= 1'b0;
					end else begin
						frame_q <= frame_q + 1'b1;
					end
				end else begin
					bit_q <= bit_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head.digits;
		end
		if (adv) begin
			data_bit_q <= frame_word[bit_q];
			pos_q <= addr[ddds_pkg::POS_W-1:0];
			bit_idx_q <= bit_q;
			frame_end_q <= frame_done;
			last_q <= final_beat;
		end
	end

endmodule

@@ hw/rtl/decimal_digit_display_serializer_core.sv @@
`timescale 1ns / 1ps

// Decimal digit display serializer.
// values: one beat carries a 14-bit unsigned number; numbers above the largest
// that DIGIT_COUNT digits can show are clamped to it (9999 for four digits).
// beats: one beat per serial bit. Each digit becomes a 16-bit frame, register
// address 1..DIGIT_COUNT in the upper byte and the digit in the lower byte,
// sent MSB first, thousands frame first. frame_end marks bit 0 of each frame,
// last marks bit 0 of the final frame. 16*DIGIT_COUNT beats per value.
// Throughput: one beat per cycle while the receiver holds ready high, set by
// the one-bit serializer. The converter takes a new value only after the load,
// 14 double-dabble steps and hand-off of the last, and runs ahead into a
// two-entry digit queue, so consecutive values go out with no gap between
// their beats. With the queue empty, a value passes the converter, the digit
// queue and the output register before its first output beat.
// Reset clears the converter, the queue and the output register; no beat is
// valid after reset. When the receiver holds ready low the output beat holds,
// the serializer waits, then the queue fills and the converter holds its
// result, keeping values.ready low until a queue entry frees.
module decimal_digit_display_serializer_core #(
	parameter int DIGIT_COUNT = 4
) (
	input logic clk,
	input logic arst_n,
	ddds_value_if.sink values,
	ddds_beat_if.source beats
);

	ddds_pkg::queue_req_t push;
	ddds_pkg::queue_req_t head;
	logic push_ready;
	logic pop;

	// front: clamp and BCD conversion
	ddds_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.values(values),
		.push(push),
		.push_ready(push_ready)
	);

	// digits of converted values waiting for the serializer
	ddds_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_ready(push_ready),
		.head(head),
		.pop(pop)
	);

	// back: frame assembly and one bit per beat
	ddds_back #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.pop(pop),
		.beats(beats)
	);

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

// Drives numbers into the serializer, rebuilds the four display frames for each accepted
// number and checks every serial bit beat against them, oldest first.
module tb_top;

	localparam int DIGITS = 4;
	localparam int BEAT_LIMIT = 10;      // mismatches printed in full
	localparam int RUN_LIMIT = 400000;   // cycles before the watchdog ends the run
	localparam int TAIL_CYCLES = 40;     // idle cycles after the owed beats have drained

	typedef struct {
		logic [ddds_pkg::VALUE_W-1:0] value;
		bit drain_first;                 // hold this number back until all beats are out
	} number_item_t;

	typedef struct packed {
		logic data_bit;
		logic [ddds_pkg::POS_W-1:0] digit_position;
		logic [ddds_pkg::BIT_W-1:0] bit_index;
		logic frame_end;
		logic last;
	} display_beat_t;

	logic clk = 1'b0;
	logic arst_n;

	ddds_value_if values_if ();
	ddds_beat_if beats_if ();

	decimal_digit_display_serializer_core #(
		.DIGIT_COUNT(DIGITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.values(values_if),
		.beats(beats_if)
	);

	always #4 clk = ~clk;

	number_item_t number_q[$];     // numbers waiting to be offered
	display_beat_t frame_beats[$]; // serial beats owed by the block, oldest first
	int beat_errors = 0;
	int cycle_count = 0;

	// Source side: gap before each number, in cycles
	int src_wait;
	bit src_burst;
	// Sink side: ready-low stretch after each beat
	int snk_wait;
	bit snk_burst;

	// Clamp to 9999, split into decimal digits (thousands first) and queue one beat
	// per frame bit. Frame = {address, digit}, address 1 is the thousands digit.
	function automatic void queue_display_frames(input logic [ddds_pkg::VALUE_W-1:0] v);
		int unsigned shown;
		int unsigned cap;
		int unsigned digit [DIGITS];
		logic [ddds_pkg::FRAME_BITS-1:0] frame;
		display_beat_t b;
		cap = 1;
		for (int k = 0; k < DIGITS; k++) begin
			cap = cap * 10;
		end
		shown = (v > cap - 1) ? cap - 1 : v;
		for (int k = DIGITS - 1; k >= 0; k--) begin
			digit[k] = shown % 10;
			shown = shown / 10;
		end
		for (int k = 0; k < DIGITS; k++) begin
			frame = {8'(k + 1), 8'(digit[k])};
			for (int i = ddds_pkg::FRAME_BITS - 1; i >= 0; i--) begin
				b.data_bit = frame[i];
				b.digit_position = ddds_pkg::POS_W'(k + 1);
				b.bit_index = ddds_pkg::BIT_W'(i);
				b.frame_end = (i == 0);
				b.last = (i == 0) && (k == DIGITS - 1);
				frame_beats.push_back(b);
			end
		end
	endfunction

	function automatic void add_number(input int unsigned v, input bit drain);
		number_item_t it;
		it.value = ddds_pkg::VALUE_W'(v);
		it.drain_first = drain;
		number_q.push_back(it);
	endfunction

	// Random number, weighted toward the displayable range, with the clamp region,
	// digit rollovers and small values each getting a share.
	function automatic int unsigned pick_number();
		int unsigned r;
		r = $urandom_range(0, 9);
		case (r)
			6: begin
				return $urandom_range(10000, ddds_pkg::VALUE_MAX);
			end
			7: begin
				return $urandom_range(0, ddds_pkg::VALUE_MAX);
			end
			8: begin
				return $urandom_range(0, 98) * 100 + 99;
			end
			9: begin
				return $urandom_range(0, 99);
			end
			default: begin
				return $urandom_range(0, 9999);
			end
		endcase
	endfunction

	// Idle draw: 0..5, except during a burst stretch where it is always 0
	function automatic int draw_gap(input bit burst);
		return burst ? 0 : $urandom_range(0, 5);
	endfunction

	// Number driver: the slot frees on acceptance or while valid is low.
	// A valid that stays high into the next number is written once per edge.
	always @(posedge clk or negedge arst_n) begin : drive_numbers
		number_item_t nxt;
		if (!arst_n) begin
			values_if.valid <= 1'b0;
			values_if.value <= '0;
			src_wait <= 0;
			src_burst <= 1'b0;
		end else begin
			if (values_if.valid && values_if.ready) begin
				queue_display_frames(values_if.value);
			end
			if (!values_if.valid || values_if.ready) begin
				if (src_wait > 0) begin
					values_if.valid <= 1'b0;
					src_wait <= src_wait - 1;
				end else if (number_q.size() != 0 &&
						!(number_q[0].drain_first && frame_beats.size() != 0)) begin
					nxt = number_q.pop_front();
					values_if.valid <= 1'b1;
					values_if.value <= nxt.value;
					if ($urandom_range(0, 15) == 0) begin
						src_burst <= ~src_burst;
					end
					src_wait <= draw_gap(src_burst);
				end else begin
					values_if.valid <= 1'b0;
				end
			end
		end
	end

	// Beat monitor: compare each accepted beat with the oldest owed one, then
	// draw how long ready stays low before the next beat.
	always @(posedge clk or negedge arst_n) begin : check_beats
		display_beat_t want;
		display_beat_t got;
		int w;
		if (!arst_n) begin
			beats_if.ready <= 1'b0;
			snk_wait <= 0;
			snk_burst <= 1'b0;
		end else begin
			if (beats_if.valid && beats_if.ready) begin
				got.data_bit = beats_if.data_bit;
				got.digit_position = beats_if.digit_position;
				got.bit_index = beats_if.bit_index;
				got.frame_end = beats_if.frame_end;
				got.last = beats_if.last;
				if (frame_beats.size() == 0) begin
					beat_errors++;
					if (beat_errors <= BEAT_LIMIT) begin
						$display("unexpected beat: bit=%0d pos=%0d idx=%0d end=%0d last=%0d",
							got.data_bit, got.digit_position, got.bit_index,
							got.frame_end, got.last);
					end
				end else begin
					want = frame_beats.pop_front();
					if (got !== want) begin
						beat_errors++;
						if (beat_errors <= BEAT_LIMIT) begin
							$display("beat mismatch: want bit=%0d pos=%0d idx=%0d end=%0d last=%0d",
								want.data_bit, want.digit_position, want.bit_index,
								want.frame_end, want.last);
							$display("                got bit=%0d pos=%0d idx=%0d end=%0d last=%0d",
								got.data_bit, got.digit_position, got.bit_index,
								got.frame_end, got.last);
						end
					end
				end
				if ($urandom_range(0, 63) == 0) begin
					snk_burst <= ~snk_burst;
				end
				w = draw_gap(snk_burst);
				if (w == 0) begin
					beats_if.ready <= 1'b1;
				end else begin
					beats_if.ready <= 1'b0;
					snk_wait <= w - 1;
				end
			end else if (!beats_if.ready) begin
				if (snk_wait == 0) begin
					beats_if.ready <= 1'b1;
				end else begin
					snk_wait <= snk_wait - 1;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == RUN_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		// known inputs before the first edge
		arst_n = 1'b0;
		values_if.valid = 1'b0;
		values_if.value = '0;
		beats_if.ready = 1'b0;

		// Directed: zero and all-ones (every value bit both ways), digit rollovers,
		// the clamp edge 9999/10000 and the top of the range.
		add_number(0, 1'b0);
		add_number(ddds_pkg::VALUE_MAX, 1'b0);
		add_number(1, 1'b0);
		add_number(9, 1'b0);
		add_number(10, 1'b0);
		add_number(99, 1'b0);
		add_number(100, 1'b0);
		add_number(999, 1'b0);
		add_number(1000, 1'b0);
		add_number(9998, 1'b0);
		add_number(9999, 1'b0);
		add_number(10000, 1'b1);  // into an idle block
		add_number(10001, 1'b0);
		add_number(8191, 1'b0);
		add_number(8192, 1'b0);
		add_number(1234, 1'b0);
		add_number(5678, 1'b0);
		add_number(9876, 1'b0);
		add_number(4321, 1'b0);
		add_number(5555, 1'b0);
		add_number(7070, 1'b0);
		add_number(2048, 1'b0);

		// Random part; every 50th number waits for the beat stream to drain
		for (int n = 0; n < 160; n++) begin
			add_number(pick_number(), (n % 50) == 25);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (number_q.size() != 0 || values_if.valid) begin
			@(posedge clk);
		end
		while (frame_beats.size() != 0) begin
			@(posedge clk);
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (frame_beats.size() != 0) begin
			beat_errors++;
		end
		if (beat_errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

@@ decimal_digit_display_serializer_core.f @@
hw/rtl/ddds_pkg.sv
hw/rtl/ddds_value_if.sv
hw/rtl/ddds_beat_if.sv
hw/rtl/ddds_front.sv
hw/rtl/ddds_fifo.sv
hw/rtl/ddds_back.sv
hw/rtl/decimal_digit_display_serializer_core.sv
tb/sv/tb_top.sv
